// File: design/fpek_pkg.sv
// Shared constants and types for the front panel encoder, keys and lamps block.
`default_nettype none

package fpek_pkg;

  localparam int CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_VOUT_MAX  = 2'd0;
  localparam cfg_idx_t REG_HOLD      = 2'd1;
  localparam cfg_idx_t REG_ADC_FAULT = 2'd2;

  localparam logic [15:0] VOUT_MAX_RST  = 16'd20000;
  localparam logic [15:0] HOLD_RST      = 16'd100;
  localparam logic [2:0]  ADC_FAULT_RST = 3'd7;

  localparam logic [15:0] STEP_FINE   = 16'd100;
  localparam logic [15:0] STEP_COARSE = 16'd1000;

  // tick_ms is split as 16 * q + lo; q is reduced modulo 125 to get the
  // 2000 ms phase.
  localparam logic [7:0] PHASE_MOD = 8'd125;

  localparam logic [10:0] HB_PERIOD   = 11'd1000;
  localparam logic [10:0] HB_ON       = 11'd500;
  localparam logic [10:0] BLINK_PITCH = 11'd300;
  localparam logic [10:0] BLINK_LEN   = 11'd150;
  localparam logic [2:0]  SHORT_CODE_LIMIT = 3'd4;

  typedef struct packed {
    logic [2:0]  fault;
    logic        out_on;
    logic        mode;
    logic        cc;
    logic [15:0] supply;
    logic [15:0] battery;
    logic [3:0]  tick_lo;
    logic [17:0] tick_fold;
  } stage_t;

endpackage

`default_nettype wire

// File: design/front_panel_encoder_keys_leds.sv
// Front panel poll block: encoder setpoint stepping, buttons, fault store and lamps.
// Each accepted poll tick passes the s1 stage register, then the output register.
// Throughput: one tick per cycle unless stalled; the phase reduction spans both stages.
// An output stall blocks the input only once both pipeline stages hold a tick.
// Reset clears all state and the pipeline; registers return to 20000 / 100 / 7.
`default_nettype none

module front_panel_encoder_keys_leds (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire fpek_pkg::cfg_idx_t     cfg_index,
  input  wire logic [15:0]            cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   enc_a,
  input  wire logic                   enc_b,
  input  wire logic                   enc_push,
  input  wire logic                   btn_output,
  input  wire logic                   btn_select,
  input  wire logic                   btn_back,
  input  wire logic [31:0]            tick_ms,
  input  wire logic                   cc_flag,
  input  wire logic [2:0]             fault_raise,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        led_heartbeat,
  output logic                        led_output,
  output logic                        led_cc,
  output logic                        output_enabled,
  output logic                        mode_out,
  output logic [2:0]                  fault_out,
  output logic [15:0]                 supply_setpoint,
  output logic [15:0]                 battery_setpoint
);
  import fpek_pkg::*;

  logic [15:0] clamp_mv;
  logic [15:0] hold_ticks;
  logic [2:0]  adc_fault_code;

  logic [1:0]  enc_last;
  logic        out_btn_last;
  logic        sel_btn_last;
  logic [15:0] back_hold_count;
  logic        mode_reg;
  logic [2:0]  fault_code;
  logic        out_on_reg;
  logic [15:0] supply_mv;
  logic [15:0] battery_mv;

  logic        s1_valid;
  stage_t      s1;
  logic        advance;
  logic        in_xfer;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = !s1_valid || advance;
  assign in_xfer   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clamp_mv       <= VOUT_MAX_RST;
      hold_ticks     <= HOLD_RST;
      adc_fault_code <= ADC_FAULT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_VOUT_MAX:  clamp_mv       <= cfg_data;
        REG_HOLD:      hold_ticks     <= cfg_data;
        REG_ADC_FAULT: adc_fault_code <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // ---- poll tick update ----
  logic [1:0]  enc_now;
  logic        dir_up;
  logic        dir_down;
  logic [15:0] step;
  logic [15:0] active_mv;
  logic [16:0] up_sum;
  logic [15:0] down_diff;
  logic [15:0] stepped_mv;
  logic [15:0] supply_mv_next;
  logic [15:0] battery_mv_next;
  logic [15:0] hold_inc;
  logic        hold_clear;
  logic [15:0] back_hold_count_next;
  logic        out_rise;
  logic        sel_rise;
  logic [2:0]  fault_code_next;
  logic        out_on_next;
  logic        mode_next;
  logic [22:0] fold_a;
  logic [17:0] fold_b;

  assign enc_now = {enc_a, enc_b};

  always_comb begin
    dir_up   = 1'b0;
    dir_down = 1'b0;
    unique case ({enc_last, enc_now}) inside
      4'b00_01, 4'b01_11, 4'b11_10, 4'b10_00: dir_up   = 1'b1;
      4'b00_10, 4'b10_11, 4'b11_01, 4'b01_00: dir_down = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    step      = enc_push ? STEP_COARSE : STEP_FINE;
    active_mv = mode_reg ? battery_mv : supply_mv;
    up_sum    = {1'b0, active_mv} + {1'b0, step};
    down_diff = (active_mv < step) ? 16'd0 : active_mv - step;
    if (dir_up) begin
      stepped_mv = (up_sum > {1'b0, clamp_mv}) ? clamp_mv : up_sum[15:0];
    end else begin
      stepped_mv = (down_diff > clamp_mv) ? clamp_mv : down_diff;
    end
    supply_mv_next  = supply_mv;
    battery_mv_next = battery_mv;
    if (dir_up || dir_down) begin
      if (mode_reg) begin
        battery_mv_next = stepped_mv;
      end else begin
        supply_mv_next = stepped_mv;
      end
    end
  end

  always_comb begin
    out_rise   = btn_output && !out_btn_last;
    sel_rise   = btn_select && !sel_btn_last;
    hold_inc   = back_hold_count + 16'd1;
    hold_clear = btn_back && (hold_inc > hold_ticks);
    if (!btn_back || hold_clear) begin
      back_hold_count_next = 16'd0;
    end else begin
      back_hold_count_next = hold_inc;
    end
    fault_code_next = (fault_raise != 3'd0) ? fault_raise : fault_code;
    if (out_rise || hold_clear) begin
      fault_code_next = 3'd0;
    end
    out_on_next = out_on_reg ^ out_rise;
    mode_next   = mode_reg ^ sel_rise;
  end

  // first two folds of tick_ms[31:4] modulo 125, using 128 = 3 (mod 125)
  always_comb begin
    fold_a = {2'b00, tick_ms[31:11]} + {1'b0, tick_ms[31:11], 1'b0}
             + {16'd0, tick_ms[10:4]};
    fold_b = {2'b00, fold_a[22:7]} + {1'b0, fold_a[22:7], 1'b0}
             + {11'd0, fold_a[6:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enc_last        <= 2'd0;
      out_btn_last    <= 1'b0;
      sel_btn_last    <= 1'b0;
      back_hold_count <= 16'd0;
      mode_reg        <= 1'b0;
      fault_code      <= 3'd0;
      out_on_reg      <= 1'b0;
      supply_mv       <= 16'd0;
      battery_mv      <= 16'd0;
    end else if (in_xfer) begin
      enc_last        <= enc_now;
      out_btn_last    <= btn_output;
      sel_btn_last    <= btn_select;
      back_hold_count <= back_hold_count_next;
      mode_reg        <= mode_next;
      fault_code      <= fault_code_next;
      out_on_reg      <= out_on_next;
      supply_mv       <= supply_mv_next;
      battery_mv      <= battery_mv_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1.fault     <= fault_code_next;
      s1.out_on    <= out_on_next;
      s1.mode      <= mode_next;
      s1.cc        <= cc_flag;
      s1.supply    <= supply_mv_next;
      s1.battery   <= battery_mv_next;
      s1.tick_lo   <= tick_ms[3:0];
      s1.tick_fold <= fold_b;
    end
  end

  // ---- lamp stage ----
  logic [12:0] fold_c;
  logic [8:0]  fold_d;
  logic [7:0]  fold_e;
  logic [6:0]  phase_q;
  logic [10:0] phase;
  logic [10:0] hb_phase;
  logic [2:0]  code;
  logic        blink_lit;
  logic        hb_next;
  logic        lo_next;
  logic        lc_next;

  always_comb begin
    fold_c = {2'b00, s1.tick_fold[17:7]} + {1'b0, s1.tick_fold[17:7], 1'b0}
             + {6'd0, s1.tick_fold[6:0]};
    fold_d = {3'b000, fold_c[12:7]} + {2'b00, fold_c[12:7], 1'b0}
             + {2'd0, fold_c[6:0]};
    fold_e = {5'd0, fold_d[8:7], 1'b0} + {6'd0, fold_d[8:7]} + {1'b0, fold_d[6:0]};
    phase_q = (fold_e >= PHASE_MOD) ? 7'(fold_e - PHASE_MOD) : fold_e[6:0];
    phase  = {phase_q, s1.tick_lo};
    hb_phase = (phase >= HB_PERIOD) ? phase - HB_PERIOD : phase;
    code   = s1.fault - 3'd1;
    blink_lit = (phase < BLINK_LEN)
             || (phase >= BLINK_PITCH && phase < BLINK_PITCH + BLINK_LEN)
             || (code >= SHORT_CODE_LIMIT && phase >= (BLINK_PITCH << 1)
                 && phase < (BLINK_PITCH << 1) + BLINK_LEN);
    if (s1.fault == 3'd0) begin
      hb_next = hb_phase < HB_ON;
      lo_next = s1.out_on;
      lc_next = s1.cc;
    end else begin
      hb_next = blink_lit || (s1.fault == adc_fault_code);
      lo_next = code[0];
      lc_next = code[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      led_heartbeat    <= hb_next;
      led_output       <= lo_next;
      led_cc           <= lc_next;
      output_enabled   <= s1.out_on;
      mode_out         <= s1.mode;
      fault_out        <= s1.fault;
      supply_setpoint  <= s1.supply;
      battery_setpoint <= s1.battery;
    end
  end

endmodule

`default_nettype wire

// File: tb/front_panel_encoder_keys_leds_tb.sv
// Self-checking testbench for the front panel poll block: directed and random poll ticks.
`timescale 1ns / 100ps

module front_panel_encoder_keys_leds_tb;
  import fpek_pkg::*;

  localparam int FINE_STEP_MV    = 100;
  localparam int COARSE_STEP_MV  = 1000;
  localparam int unsigned BEAT_MS         = 1000;
  localparam int unsigned BEAT_ON_MS      = 500;
  localparam int unsigned BLINK_CYCLE_MS  = 2000;
  localparam int unsigned BLINK_GAP_MS    = 300;
  localparam int unsigned BLINK_ON_MS     = 150;
  localparam int unsigned FEW_BLINK_CODES = 4;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic        enc_a;
    logic        enc_b;
    logic        enc_push;
    logic        btn_output;
    logic        btn_select;
    logic        btn_back;
    logic [31:0] tick_ms;
    logic        cc_flag;
    logic [2:0]  fault_raise;
  } poll_t;

  typedef struct {
    logic        led_heartbeat;
    logic        led_output;
    logic        led_cc;
    logic        output_enabled;
    logic        mode_out;
    logic [2:0]  fault_out;
    logic [15:0] supply_setpoint;
    logic [15:0] battery_setpoint;
  } panel_t;

  class panel_scoreboard;
    logic [15:0] vout_max   = 16'd20000;
    logic [15:0] hold_limit = 16'd100;
    logic [2:0]  adc_code   = 3'd7;
    logic [1:0]  enc_prev   = 2'b00;
    logic        out_prev   = 1'b0;
    logic        sel_prev   = 1'b0;
    logic [15:0] back_count = 16'd0;
    logic        battery_mode = 1'b0;
    logic [2:0]  fault      = 3'd0;
    logic        out_on     = 1'b0;
    logic [15:0] supply_mv  = 16'd0;
    logic [15:0] battery_mv = 16'd0;
    panel_t      expected_panels[$];
    int          failures   = 0;

    function void set_reg(cfg_idx_t idx, logic [15:0] val);
      case (idx)
        REG_VOUT_MAX:  vout_max = val;
        REG_HOLD:      hold_limit = val;
        REG_ADC_FAULT: adc_code = val[2:0];
        default: ;
      endcase
    endfunction

    function int quad_dir(logic [1:0] from, logic [1:0] to);
      case ({from, to})
        4'b0001, 4'b0111, 4'b1110, 4'b1000: return 1;
        4'b0010, 4'b1011, 4'b1101, 4'b0100: return -1;
        default: return 0;
      endcase
    endfunction

    function logic [15:0] nudge(logic [15:0] mv, int dir, int stride);
      int x;
      x = int'(mv) + dir * stride;
      if (x < 0) x = 0;
      if (x > int'(vout_max)) x = int'(vout_max);
      return x[15:0];
    endfunction

    function void poll_accepted(poll_t p);
      panel_t      e;
      logic [1:0]  pos;
      logic [2:0]  code;
      int          dir;
      int unsigned phase;
      int unsigned blinks;
      if (p.fault_raise != 3'd0) fault = p.fault_raise;
      pos = {p.enc_a, p.enc_b};
      if (pos != enc_prev) begin
        dir = quad_dir(enc_prev, pos);
        if (dir != 0) begin
          if (battery_mode)
            battery_mv = nudge(battery_mv, dir, p.enc_push ? COARSE_STEP_MV : FINE_STEP_MV);
          else
            supply_mv = nudge(supply_mv, dir, p.enc_push ? COARSE_STEP_MV : FINE_STEP_MV);
        end
        enc_prev = pos;
      end
      if (p.btn_output && !out_prev) begin
        fault = 3'd0;
        out_on = ~out_on;
      end
      if (p.btn_select && !sel_prev) battery_mode = ~battery_mode;
      if (p.btn_back) begin
        back_count = back_count + 16'd1;
        if (back_count > hold_limit) begin
          fault = 3'd0;
          back_count = 16'd0;
        end
      end else begin
        back_count = 16'd0;
      end
      out_prev = p.btn_output;
      sel_prev = p.btn_select;

      if (fault == 3'd0) begin
        e.led_heartbeat = (p.tick_ms % BEAT_MS) < BEAT_ON_MS;
        e.led_output = out_on;
        e.led_cc = p.cc_flag;
      end else begin
        code = fault - 3'd1;
        blinks = (code < FEW_BLINK_CODES) ? 2 : 3;
        phase = p.tick_ms % BLINK_CYCLE_MS;
        e.led_heartbeat = 1'b0;
        for (int unsigned i = 0; i < blinks; i++)
          if (phase >= i * BLINK_GAP_MS && phase < i * BLINK_GAP_MS + BLINK_ON_MS)
            e.led_heartbeat = 1'b1;
        if (fault == adc_code) e.led_heartbeat = 1'b1;
        e.led_output = code[0];
        e.led_cc = code[1];
      end
      e.output_enabled = out_on;
      e.mode_out = battery_mode;
      e.fault_out = fault;
      e.supply_setpoint = supply_mv;
      e.battery_setpoint = battery_mv;
      expected_panels.push_back(e);
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        failures++;
        $error("%s: expected %0d, got %0d", field, want, got);
      end
    endfunction

    function void check_panel(panel_t got);
      panel_t want;
      if (expected_panels.size() == 0) begin
        failures++;
        $error("result transfer with nothing expected");
        return;
      end
      want = expected_panels.pop_front();
      compare("led_heartbeat", 32'(want.led_heartbeat), 32'(got.led_heartbeat));
      compare("led_output", 32'(want.led_output), 32'(got.led_output));
      compare("led_cc", 32'(want.led_cc), 32'(got.led_cc));
      compare("output_enabled", 32'(want.output_enabled), 32'(got.output_enabled));
      compare("mode_out", 32'(want.mode_out), 32'(got.mode_out));
      compare("fault_out", 32'(want.fault_out), 32'(got.fault_out));
      compare("supply_setpoint", 32'(want.supply_setpoint), 32'(got.supply_setpoint));
      compare("battery_setpoint", 32'(want.battery_setpoint), 32'(got.battery_setpoint));
    endfunction

    function int pending();
      return expected_panels.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = REG_VOUT_MAX;
  logic [15:0] cfg_data = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        enc_a = 1'b0;
  logic        enc_b = 1'b0;
  logic        enc_push = 1'b0;
  logic        btn_output = 1'b0;
  logic        btn_select = 1'b0;
  logic        btn_back = 1'b0;
  logic [31:0] tick_ms = 32'd0;
  logic        cc_flag = 1'b0;
  logic [2:0]  fault_raise = 3'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        led_heartbeat;
  logic        led_output;
  logic        led_cc;
  logic        output_enabled;
  logic        mode_out;
  logic [2:0]  fault_out;
  logic [15:0] supply_setpoint;
  logic [15:0] battery_setpoint;

  panel_scoreboard sb = new;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int enc_way = 1;
  int idle_cycles = 0;

  front_panel_encoder_keys_leds uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .enc_a(enc_a), .enc_b(enc_b), .enc_push(enc_push),
    .btn_output(btn_output), .btn_select(btn_select), .btn_back(btn_back),
    .tick_ms(tick_ms), .cc_flag(cc_flag), .fault_raise(fault_raise),
    .out_valid(out_valid), .out_ready(out_ready),
    .led_heartbeat(led_heartbeat), .led_output(led_output), .led_cc(led_cc),
    .output_enabled(output_enabled), .mode_out(mode_out), .fault_out(fault_out),
    .supply_setpoint(supply_setpoint), .battery_setpoint(battery_setpoint)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // transfers are taken at the rising edge; the watchdog counts edges with none
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
      if (in_valid && in_ready)
        sb.poll_accepted(poll_t'{enc_a, enc_b, enc_push, btn_output, btn_select, btn_back,
                                 tick_ms, cc_flag, fault_raise});
      if (out_valid && out_ready)
        sb.check_panel(panel_t'{led_heartbeat, led_output, led_cc, output_enabled, mode_out,
                                fault_out, supply_setpoint, battery_setpoint});
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("front_panel_encoder_keys_leds_tb NOT OK");
        $finish;
      end
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [15:0] vmax, input logic [15:0] hold,
                               input logic [2:0] adc);
    write_reg(REG_VOUT_MAX, vmax);
    write_reg(REG_HOLD, hold);
    write_reg(REG_ADC_FAULT, {13'd0, adc});
    cfg_valid <= 1'b0;
  endtask

  task automatic drive_poll(input logic a, input logic b, input logic push, input logic bo,
                            input logic bs, input logic bb, input logic cc,
                            input logic [2:0] raise, input logic [31:0] ms);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    enc_a <= a;
    enc_b <= b;
    enc_push <= push;
    btn_output <= bo;
    btn_select <= bs;
    btn_back <= bb;
    cc_flag <= cc;
    fault_raise <= raise;
    tick_ms <= ms;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [1:0] gray_step(logic [1:0] pos, int way);
    logic [1:0] ring [4];
    int idx;
    ring = '{2'b00, 2'b01, 2'b11, 2'b10};
    idx = pos[1] ? (pos[0] ? 2 : 3) : (pos[0] ? 1 : 0);
    return ring[2'((idx + way + 4) % 4)];
  endfunction

  // mostly clean quadrature runs in one direction, with stalls, reversals and skipped states
  task automatic random_poll();
    logic [1:0]  pos;
    logic [31:0] ms;
    int unsigned r;
    pos = {enc_a, enc_b};
    if ($urandom_range(99) < 8) enc_way = -enc_way;
    r = $urandom_range(99);
    if (r < 75) pos = gray_step(pos, enc_way);
    else if (r >= 85 && r < 92) pos = ~pos;
    else if (r >= 92) pos = gray_step(pos, -enc_way);
    if ($urandom_range(99) < 8) ms = $urandom();
    else ms = tick_ms + $urandom_range(400);
    drive_poll(pos[1], pos[0], $urandom_range(99) < 35,
               btn_output ^ ($urandom_range(99) < 15),
               btn_select ^ ($urandom_range(99) < 15),
               btn_back ^ ($urandom_range(99) < 10),
               1'($urandom_range(1)),
               ($urandom_range(99) < 12) ? 3'($urandom_range(7, 1)) : 3'd0, ms);
  endtask

  initial begin
    logic [15:0] vmax_set [6];
    logic [15:0] hold_set [6];
    logic [2:0]  adc_set [6];
    vmax_set = '{16'd65535, 16'd0, 16'd5000, 16'd65535, 16'd2500, 16'd20000};
    hold_set = '{16'd65534, 16'd2, 16'd1, 16'd12, 16'd65534, 16'd3};
    adc_set  = '{3'd1, 3'd7, 3'd4, 3'd2, 3'd5, 3'd6};
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset register values
    drive_poll(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 32'd0);
    drive_poll(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 3'd7, 32'hFFFF_FFFF);
    drive_poll(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 32'd499);
    drive_poll(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 3'd0, 32'd500);
    drive_poll(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 3'd3, 32'd2299);
    drive_poll(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 32'd2300);
    drive_poll(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 3'd0, 32'd2449);
    drive_poll(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 32'd2450);
    drive_poll(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 3'd0, 32'd999);
    drive_poll(1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 3'd5, 32'd600);
    drive_poll(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 3'd0, 32'd749);
    drive_poll(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 3'd0, 32'd750);
    drive_poll(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 3'd0, 32'd1000);
    drive_poll(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 3'd1, 32'd149);
    drive_poll(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 3'd2, 32'd1999);
    drain();

    // clamp below the supply setpoint, short BACK hold
    apply_setting(16'd1500, 16'd1, 3'd3);
    drive_poll(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 3'd4, 32'd4300);
    drive_poll(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 3'd0, 32'd0);
    drive_poll(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 3'd3, 32'd7);
    drive_poll(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 3'd6, 32'd8);
    drive_poll(1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 3'd3, 32'd1000);
    drive_poll(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 3'd6, 32'd2000);
    drive_poll(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 3'd7, 32'h8000_0000);
    drive_poll(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 3'd7, 32'hFFFF_FFFF);
    drive_poll(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 32'h7FFF_FFFF);

    for (int k = 0; k < 6; k++) begin
      drain();
      send_idle_pct = (k < 2) ? 12 : (k < 4) ? 66 : 0;
      recv_idle_pct = (k < 2) ? 66 : (k < 4) ? 12 : 0;
      apply_setting(vmax_set[k], hold_set[k], adc_set[k]);
      repeat (185) random_poll();
    end
    drain();

    if (sb.failures == 0 && sb.pending() == 0)
      $display("front_panel_encoder_keys_leds_tb OK");
    else
      $display("front_panel_encoder_keys_leds_tb NOT OK");
    $finish;
  end

endmodule

// File: filelist.f
design/fpek_pkg.sv
design/front_panel_encoder_keys_leds.sv
tb/front_panel_encoder_keys_leds_tb.sv
